[design/mmfpa_pkg.sv]
// Package for the max-min fair partition allocator.
// Holds sizes, widths, operation and status codes and the sequencer states.
// Used by the core and by the testbench; the generic RAM does not depend on it.
package mmfpa_pkg;

  localparam int MAX_MODELS = 16;
  localparam int MAX_SIZES  = 8;

  localparam int MCW   = $clog2(MAX_MODELS + 1);
  localparam int SCNTW = $clog2(MAX_SIZES + 1);
  localparam int SCW   = (MCW > SCNTW) ? MCW : SCNTW;
  localparam int MAW   = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
  localparam int SAW   = (MAX_SIZES > 1) ? $clog2(MAX_SIZES) : 1;

  localparam int ID_W   = 8;
  localparam int DEM_W  = 10;
  localparam int SIZE_W = 7;
  localparam int CNT_W  = 10;
  localparam int TOT_W  = 11;
  localparam int GPU_W  = 4;
  localparam int AV_W   = 12;
  localparam int DIVW   = 11;
  localparam int DVSW   = 7;
  localparam int DCW    = $clog2(DIVW);
  localparam int KEY_W  = DEM_W + MAW;
  localparam int MEM_W  = ID_W + DEM_W;

  localparam int SHARE_PER_GPU = 100;
  localparam logic [GPU_W-1:0] GPUS_RESET = GPU_W'(4);

  typedef enum logic [1:0] {
    OP_LOAD_MODEL = 2'd0,
    OP_LOAD_SIZE  = 2'd1,
    OP_ALLOC      = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SIZES  = 2'd1,
    STAT_DROPPED   = 2'd2,
    STAT_NO_MODELS = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRCH = 7'b0000010,
    S_SMAX = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MSEL = 7'b0010000,
    S_TAIL = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

[design/max_min_fair_part_allocator_core.sv]
// Max-min fair partition allocator core. A model load into an empty table is written directly;
// otherwise the table is searched for a repeated id through its single read port. An allocate
// transaction uses, per model, the shared bit-serial divider up to twice, a walk of the model
// table to pick the next model by demand and a walk of the size table to pick the tail piece,
// plus one walk of the size table for the largest size; all these walks go through the one
// read port of each table.
// Depends on mmfpa_pkg and mmfpa_ram.
module max_min_fair_part_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmfpa_pkg::GPU_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      opcode_i,
  input  logic [mmfpa_pkg::ID_W-1:0]      load_id_i,
  input  logic [mmfpa_pkg::DEM_W-1:0]     demand_i,
  input  logic [mmfpa_pkg::SIZE_W-1:0]    part_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mmfpa_pkg::ID_W-1:0]      grant_id_o,
  output logic [mmfpa_pkg::CNT_W-1:0]     largest_piece_count_o,
  output logic [mmfpa_pkg::SIZE_W-1:0]    tail_piece_o,
  output logic [mmfpa_pkg::TOT_W-1:0]     granted_total_o,
  output logic                            is_last_o,
  output logic [1:0]                      status_o
);
  import mmfpa_pkg::*;

  state_e state_q, state_d;
  logic [GPU_W-1:0] gpus_q;
  logic [MCW-1:0] mcnt_q, mcnt_d, pos_q, pos_d;
  logic [SCNTW-1:0] scnt_q, scnt_d;
  logic drop_q, drop_d;
  logic [SCW-1:0] scan_q, scan_d, pidx_q, pidx_d;
  logic pv_q, pv_d;
  logic [ID_W-1:0] ld_id_q, ld_id_d;
  logic [DEM_W-1:0] ld_dem_q, ld_dem_d;
  logic [1:0] stat_q, stat_d;
  logic signed [AV_W-1:0] avail_q, avail_d, avail_nxt;
  logic [SIZE_W-1:0] big_q, big_d;
  logic [DIVW-1:0] share_q, share_d;
  logic [KEY_W-1:0] last_q, last_d, bkey_q, bkey_d;
  logic bf_q, bf_d;
  logic [ID_W-1:0] bid_q, bid_d;
  logic [DEM_W-1:0] need_q, need_d;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic [SIZE_W-1:0] r_q, r_d, tail_q, tail_d;
  logic [DIVW-1:0] dnum_q, dnum_d, dquo_q, dquo_d;
  logic [DVSW-1:0] dden_q, dden_d, drem_q, drem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic dpc_q, dpc_d;
  logic ov_q, ov_d, olast_q, olast_d;
  logic [ID_W-1:0] oid_q, oid_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic [SIZE_W-1:0] otail_q, otail_d;
  logic [TOT_W-1:0] otot_q, otot_d;
  logic [1:0] ostat_q, ostat_d;

  logic m_we, s_we;
  logic [MAW-1:0] m_waddr;
  logic [SAW-1:0] s_waddr;
  logic [MEM_W-1:0] m_wdata, m_rdata;
  logic [SIZE_W-1:0] s_wdata, s_rdata;
  logic [ID_W-1:0] rd_id;
  logic [DEM_W-1:0] rd_dem;
  logic [KEY_W-1:0] rd_key;
  logic [DVSW:0] dtrial;
  logic [DIVW-1:0] need_w;
  logic in_acc, out_acc;

  mmfpa_ram #(.WIDTH(MEM_W), .DEPTH(MAX_MODELS)) u_model_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (scan_q[MAW-1:0]),
    .rdata_o (m_rdata)
  );

  mmfpa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_SIZES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (scan_q[SAW-1:0]),
    .rdata_o (s_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_acc    = ov_q && !out_stall_i;
  assign rd_id      = m_rdata[MEM_W-1:DEM_W];
  assign rd_dem     = m_rdata[DEM_W-1:0];
  assign rd_key     = {rd_dem, pidx_q[MAW-1:0]};
  assign dtrial     = {drem_q, dnum_q[DIVW-1]};
  assign avail_nxt  = avail_q - AV_W'(otot_q);
  assign need_w     = (DIVW'(bkey_q[KEY_W-1:MAW]) < share_q) ? DIVW'(bkey_q[KEY_W-1:MAW])
                                                             : share_q;

  always_comb begin
    state_d = state_q; mcnt_d = mcnt_q; pos_d = pos_q; scnt_d = scnt_q; drop_d = drop_q;
    scan_d = scan_q; pidx_d = pidx_q; pv_d = 1'b0; ld_id_d = ld_id_q; ld_dem_d = ld_dem_q;
    stat_d = stat_q; avail_d = avail_q; big_d = big_q; share_d = share_q; last_d = last_q;
    bkey_d = bkey_q; bf_d = bf_q; bid_d = bid_q; need_d = need_q; pcnt_d = pcnt_q;
    r_d = r_q; tail_d = tail_q; dnum_d = dnum_q; dquo_d = dquo_q; dden_d = dden_q;
    drem_d = drem_q; dcnt_d = dcnt_q; dpc_d = dpc_q; ov_d = ov_q; olast_d = olast_q;
    oid_d = oid_q; ocnt_d = ocnt_q; otail_d = otail_q; otot_d = otot_q; ostat_d = ostat_q;
    m_we = 1'b0; m_waddr = mcnt_q[MAW-1:0]; m_wdata = {ld_id_q, ld_dem_q};
    s_we = 1'b0; s_waddr = scnt_q[SAW-1:0]; s_wdata = part_size_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ld_id_d  = load_id_i;
          ld_dem_d = demand_i;
          scan_d   = '0;
          unique case (opcode_i)
            OP_LOAD_MODEL: begin
              if (mcnt_q == '0) begin
                m_we    = 1'b1;
                m_wdata = {load_id_i, demand_i};
                mcnt_d  = MCW'(1);
              end else begin
                state_d = S_SRCH;
              end
            end
            OP_LOAD_SIZE: begin
              if (part_size_i == '0 || scnt_q == SCNTW'(MAX_SIZES)) begin
                drop_d = 1'b1;
              end else begin
                s_we   = 1'b1;
                scnt_d = scnt_q + SCNTW'(1);
              end
            end
            OP_ALLOC: begin
              pos_d   = '0;
              avail_d = AV_W'(gpus_q * SHARE_PER_GPU);
              big_d   = '0;
              if (mcnt_q == '0) begin
                oid_d = '0; ocnt_d = '0; otail_d = '0; otot_d = '0;
                olast_d = 1'b1; ostat_d = STAT_NO_MODELS; ov_d = 1'b1;
                state_d = S_OUT;
              end else begin
                stat_d  = (scnt_q == '0) ? STAT_NO_SIZES : (drop_q ? STAT_DROPPED : STAT_OK);
                state_d = S_SMAX;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (scan_q < SCW'(mcnt_q)) begin
          scan_d = scan_q + SCW'(1); pv_d = 1'b1; pidx_d = scan_q;
        end
        if (pv_q && rd_id == ld_id_q) begin
          m_we    = 1'b1;
          m_waddr = pidx_q[MAW-1:0];
          state_d = S_IDLE;
        end else if (!pv_q && scan_q == SCW'(mcnt_q)) begin
          if (mcnt_q == MCW'(MAX_MODELS)) begin
            drop_d = 1'b1;
          end else begin
            m_we   = 1'b1;
            mcnt_d = mcnt_q + MCW'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_SMAX: begin
        if (scan_q < SCW'(scnt_q)) begin
          scan_d = scan_q + SCW'(1); pv_d = 1'b1; pidx_d = scan_q;
        end
        if (pv_q && s_rdata > big_q) begin
          big_d = s_rdata;
        end
        if (!pv_q && scan_q == SCW'(scnt_q)) begin
          if (avail_q > 0) begin
            dnum_d = DIVW'(avail_q); dden_d = DVSW'(mcnt_q - pos_q);
            drem_d = '0; dcnt_d = '0; dpc_d = 1'b0; state_d = S_DIV;
          end else begin
            share_d = '0; scan_d = '0; bf_d = 1'b0; state_d = S_MSEL;
          end
        end
      end
      S_DIV: begin
        dnum_d = {dnum_q[DIVW-2:0], 1'b0};
        if (dtrial >= {1'b0, dden_q}) begin
          drem_d = DVSW'(dtrial - {1'b0, dden_q});
          dquo_d = {dquo_q[DIVW-2:0], 1'b1};
        end else begin
          drem_d = dtrial[DVSW-1:0];
          dquo_d = {dquo_q[DIVW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(DIVW - 1)) begin
          scan_d = '0;
          if (dpc_q) begin
            pcnt_d = CNT_W'(dquo_d); r_d = drem_d; tail_d = '0; state_d = S_TAIL;
          end else begin
            share_d = dquo_d; bf_d = 1'b0; state_d = S_MSEL;
          end
        end
      end
      S_MSEL: begin
        if (scan_q < SCW'(mcnt_q)) begin
          scan_d = scan_q + SCW'(1); pv_d = 1'b1; pidx_d = scan_q;
        end
        if (pv_q && (pos_q == '0 || rd_key > last_q) && (!bf_q || rd_key < bkey_q)) begin
          bf_d = 1'b1; bkey_d = rd_key; bid_d = rd_id;
        end
        if (!pv_q && scan_q == SCW'(mcnt_q)) begin
          last_d  = bkey_q;
          need_d  = DEM_W'(need_w);
          oid_d   = bid_q;
          olast_d = (pos_q + MCW'(1) == mcnt_q);
          ostat_d = stat_q;
          if (scnt_q == '0 || need_w == '0) begin
            ocnt_d = '0; otail_d = '0; otot_d = '0; ov_d = 1'b1; state_d = S_OUT;
          end else begin
            dnum_d = need_w - DIVW'(1); dden_d = DVSW'(big_q);
            drem_d = '0; dcnt_d = '0; dpc_d = 1'b1; state_d = S_DIV;
          end
        end
      end
      S_TAIL: begin
        if (scan_q < SCW'(scnt_q)) begin
          scan_d = scan_q + SCW'(1); pv_d = 1'b1; pidx_d = scan_q;
        end
        if (pv_q && s_rdata > r_q && (tail_q == '0 || s_rdata < tail_q)) begin
          tail_d = s_rdata;
        end
        if (!pv_q && scan_q == SCW'(scnt_q)) begin
          ocnt_d  = pcnt_q;
          otail_d = tail_q;
          otot_d  = TOT_W'(need_q) - TOT_W'(1) - TOT_W'(r_q) + TOT_W'(tail_q);
          ov_d    = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          ov_d    = 1'b0;
          avail_d = avail_nxt;
          pos_d   = pos_q + MCW'(1);
          scan_d  = '0;
          if (olast_q) begin
            mcnt_d = '0; scnt_d = '0; drop_d = 1'b0; state_d = S_IDLE;
          end else if (avail_nxt > 0) begin
            dnum_d = DIVW'(avail_nxt); dden_d = DVSW'(mcnt_q - pos_q - MCW'(1));
            drem_d = '0; dcnt_d = '0; dpc_d = 1'b0; state_d = S_DIV;
          end else begin
            share_d = '0; bf_d = 1'b0; state_d = S_MSEL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gpus_q  <= GPUS_RESET;
      mcnt_q  <= '0;
      scnt_q  <= '0;
      drop_q  <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gpus_q <= cfg_wdata_i;
      end
      mcnt_q <= mcnt_d;
      scnt_q <= scnt_d;
      drop_q <= drop_d;
      pv_q   <= pv_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; scan_q <= scan_d; pidx_q <= pidx_d; ld_id_q <= ld_id_d;
    ld_dem_q <= ld_dem_d; stat_q <= stat_d; avail_q <= avail_d; big_q <= big_d;
    share_q <= share_d; last_q <= last_d; bkey_q <= bkey_d; bf_q <= bf_d; bid_q <= bid_d;
    need_q <= need_d; pcnt_q <= pcnt_d; r_q <= r_d; tail_q <= tail_d; dnum_q <= dnum_d;
    dquo_q <= dquo_d; dden_q <= dden_d; drem_q <= drem_d; dcnt_q <= dcnt_d; dpc_q <= dpc_d;
    olast_q <= olast_d; oid_q <= oid_d; ocnt_q <= ocnt_d; otail_q <= otail_d;
    otot_q <= otot_d; ostat_q <= ostat_d;
  end

  assign out_valid_o           = ov_q;
  assign grant_id_o            = oid_q;
  assign largest_piece_count_o = ocnt_q;
  assign tail_piece_o          = otail_q;
  assign granted_total_o       = otot_q;
  assign is_last_o             = olast_q;
  assign status_o              = ostat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= MCW'(MAX_MODELS) && scnt_q <= SCNTW'(MAX_SIZES))
    else $error("table count beyond capacity");

  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> state_q == S_OUT)
    else $error("result shown outside the output state");

  a_clear_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && olast_q) |=> (mcnt_q == '0 && scnt_q == '0 && !drop_q))
    else $error("tables not cleared after the last result");

  a_no_model_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ostat_q == STAT_NO_MODELS) |-> (olast_q && otot_q == '0))
    else $error("empty run result malformed");

endmodule

[design/mmfpa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the model table and the size table.
module mmfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[bench/mmfpa_checker.sv]
`timescale 1ns / 100ps
// Checker for the max-min fair partition allocator: watches both channels and the
// configuration port, predicts every allocation result and compares it field by field.
// Depends on mmfpa_pkg.
module mmfpa_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmfpa_pkg::GPU_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [1:0]                       opcode_i,
  input  logic [mmfpa_pkg::ID_W-1:0]       load_id_i,
  input  logic [mmfpa_pkg::DEM_W-1:0]      demand_i,
  input  logic [mmfpa_pkg::SIZE_W-1:0]     part_size_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [mmfpa_pkg::ID_W-1:0]       grant_id_i,
  input  logic [mmfpa_pkg::CNT_W-1:0]      largest_piece_count_i,
  input  logic [mmfpa_pkg::SIZE_W-1:0]     tail_piece_i,
  input  logic [mmfpa_pkg::TOT_W-1:0]      granted_total_i,
  input  logic                             is_last_i,
  input  logic [1:0]                       status_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import mmfpa_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  cnt;
    logic [SIZE_W-1:0] tail;
    logic [TOT_W-1:0]  total;
    logic              last;
    logic [1:0]        status;
  } grant_t;

  grant_t grants_q[$];
  logic [GPU_W-1:0] gpus;
  logic [ID_W-1:0] ids[MAX_MODELS];
  logic [DEM_W-1:0] dems[MAX_MODELS];
  logic [SIZE_W-1:0] sizes[MAX_SIZES];
  int n_models, n_sizes;
  bit dropped;

  assign pending_o = grants_q.size();

  task automatic load_demand(input logic [ID_W-1:0] id, input logic [DEM_W-1:0] d);
    for (int i = 0; i < n_models; i++)
      if (ids[i] == id) begin
        dems[i] = d;
        return;
      end
    if (n_models < MAX_MODELS) begin
      ids[n_models] = id;
      dems[n_models] = d;
      n_models++;
    end else begin
      dropped = 1;
    end
  endtask

  task automatic allocate_shares();
    int order[MAX_MODELS];
    int j, v, avail, share, need, big, cnt, tail, total;
    logic [1:0] st;
    logic [SIZE_W-1:0] sv;
    grant_t g;
    if (n_models == 0) begin
      g = '0;
      g.last = 1;
      g.status = STAT_NO_MODELS;
      grants_q.insert(grants_q.size(), g);
    end else begin
      st = (n_sizes == 0) ? STAT_NO_SIZES : (dropped ? STAT_DROPPED : STAT_OK);
      for (int i = 0; i < n_models; i++) begin
        v = i;
        j = i;
        while (j > 0 && dems[order[j-1]] > dems[v]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      for (int i = 1; i < n_sizes; i++) begin
        sv = sizes[i];
        j = i;
        while (j > 0 && sizes[j-1] > sv) begin
          sizes[j] = sizes[j-1];
          j--;
        end
        sizes[j] = sv;
      end
      avail = gpus * SHARE_PER_GPU;
      share = avail / n_models;
      for (int i = 0; i < n_models; i++) begin
        need = dems[order[i]];
        cnt = 0;
        tail = 0;
        total = 0;
        if (need > share) need = share;
        if (n_sizes > 0 && need > 0) begin
          big = sizes[n_sizes-1];
          cnt = (need - 1) / big;
          need -= cnt * big;
          for (int k = 0; k < n_sizes; k++)
            if (sizes[k] >= need) begin
              tail = sizes[k];
              break;
            end
          total = cnt * big + tail;
        end
        avail -= total;
        if (n_models - 1 - i != 0) share = avail / (n_models - 1 - i);
        g.id = ids[order[i]];
        g.cnt = cnt;
        g.tail = tail;
        g.total = total;
        g.last = (i + 1 == n_models);
        g.status = st;
        grants_q.insert(grants_q.size(), g);
      end
    end
    n_models = 0;
    n_sizes = 0;
    dropped = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t e, a;
    if (!rst_ni) begin
      gpus = GPUS_RESET;
      n_models = 0;
      n_sizes = 0;
      dropped = 0;
      fail_count_o = 0;
      grants_q.delete();
    end else begin
      if (cfg_we_i) gpus = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        case (opcode_i)
          OP_LOAD_MODEL: load_demand(load_id_i, demand_i);
          OP_LOAD_SIZE: begin
            if (part_size_i == 0 || n_sizes >= MAX_SIZES) dropped = 1;
            else sizes[n_sizes++] = part_size_i;
          end
          OP_ALLOC: allocate_shares();
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        a = {grant_id_i, largest_piece_count_i, tail_piece_i, granted_total_i,
             is_last_i, status_i};
        if (grants_q.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, a);
          fail_count_o++;
        end else begin
          e = grants_q.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected id=%0d cnt=%0d tail=%0d tot=%0d last=%0d st=%0d",
                     $time, e.id, e.cnt, e.tail, e.total, e.last, e.status);
            $display("%0t:            actual id=%0d cnt=%0d tail=%0d tot=%0d last=%0d st=%0d",
                     $time, a.id, a.cnt, a.tail, a.total, a.last, a.status);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[bench/tb_max_min_fair_part_allocator_core.sv]
`timescale 1ns / 100ps
// Testbench top for max_min_fair_part_allocator_core: drives loads, allocate commands and
// GPU-count writes with random gaps and stalls, and reports the verdict of mmfpa_checker.
// Depends on mmfpa_pkg, mmfpa_checker and the core.
module tb_max_min_fair_part_allocator_core;
  import mmfpa_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we = 0;
  logic [GPU_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] opcode = '0;
  logic [ID_W-1:0] load_id = '0;
  logic [DEM_W-1:0] demand = '0;
  logic [SIZE_W-1:0] part_size = '0;
  logic [ID_W-1:0] r_id;
  logic [CNT_W-1:0] r_cnt;
  logic [SIZE_W-1:0] r_tail;
  logic [TOT_W-1:0] r_total;
  logic r_last;
  logic [1:0] r_status;
  int fails, pending, cycles, sent;
  bit hold_off = 0;

  always #6 clk_i = ~clk_i;

  max_min_fair_part_allocator_core dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .opcode_i(opcode),
    .load_id_i(load_id), .demand_i(demand), .part_size_i(part_size),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .grant_id_o(r_id),
    .largest_piece_count_o(r_cnt), .tail_piece_o(r_tail), .granted_total_o(r_total),
    .is_last_o(r_last), .status_o(r_status)
  );

  mmfpa_checker chk (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .opcode_i(opcode),
    .load_id_i(load_id), .demand_i(demand), .part_size_i(part_size),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .grant_id_i(r_id),
    .largest_piece_count_i(r_cnt), .tail_piece_i(r_tail), .granted_total_i(r_total),
    .is_last_i(r_last), .status_i(r_status), .fail_count_o(fails), .pending_o(pending)
  );

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      g = (cycles % 3000 < 1500) ? gap_len() : 0;
      if (g != 0) begin
        out_stall <= 1;
        repeat (g) @(posedge clk_i);
      end
      out_stall <= 0;
    end
  end

  task automatic send(input logic [1:0] op, input logic [ID_W-1:0] id,
                      input logic [DEM_W-1:0] d, input logic [SIZE_W-1:0] sz);
    int g;
    g = (sent % 100 < 70) ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1;
    opcode <= op;
    load_id <= id;
    demand <= d;
    part_size <= sz;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic drain_and_config(input logic [GPU_W-1:0] v);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  task automatic random_run();
    int nm, ns, r;
    nm = $urandom_range(0, 99) < 5 ? $urandom_range(17, 19) : $urandom_range(0, 8);
    ns = $urandom_range(0, 99) < 5 ? $urandom_range(9, 10) : $urandom_range(0, 4);
    repeat (nm + ns) begin
      r = $urandom_range(0, 99);
      if (r < 3) send(OP_RESERVED, ID_W'($urandom), DEM_W'($urandom), SIZE_W'($urandom));
      else if ($urandom_range(0, nm + ns) < nm)
        send(OP_LOAD_MODEL,
             ($urandom_range(0, 99) < 20) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom),
             ($urandom_range(0, 3) == 0) ? DEM_W'($urandom) : DEM_W'($urandom_range(0, 200)),
             SIZE_W'($urandom));
      else
        send(OP_LOAD_SIZE, ID_W'($urandom), DEM_W'($urandom),
             ($urandom_range(0, 19) == 0) ? SIZE_W'(0) : (($urandom_range(0, 9) == 0) ?
             SIZE_W'($urandom_range(1, 127)) : SIZE_W'($urandom_range(1, 100))));
    end
    send(OP_ALLOC, ID_W'($urandom), DEM_W'($urandom), SIZE_W'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(OP_ALLOC, 8'hff, '1, '1);
    send(OP_LOAD_MODEL, 8'd0, 10'd0, '0);
    send(OP_LOAD_MODEL, 8'hff, 10'h3ff, '0);
    send(OP_LOAD_MODEL, 8'd5, 10'd150, '0);
    send(OP_LOAD_MODEL, 8'd0, 10'd150, '0);
    send(OP_RESERVED, 8'hff, '1, '1);
    send(OP_ALLOC, '0, '0, '0);
    send(OP_LOAD_SIZE, '0, '0, 7'd100);
    send(OP_LOAD_SIZE, '0, '0, 7'd1);
    send(OP_LOAD_SIZE, '0, '0, 7'd127);
    send(OP_LOAD_SIZE, '0, '0, 7'd0);
    send(OP_LOAD_MODEL, 8'd7, 10'd1023, '0);
    send(OP_LOAD_MODEL, 8'd8, 10'd1, '0);
    send(OP_ALLOC, '0, '0, '0);
    for (int i = 0; i < 17; i++) send(OP_LOAD_MODEL, ID_W'(i), 10'd60, '0);
    for (int i = 0; i < 9; i++) send(OP_LOAD_SIZE, '0, '0, SIZE_W'(30 + i));
    send(OP_ALLOC, '0, '0, '0);
    drain_and_config(GPU_W'(8));
    // Over-allocation drives the pool negative.
    send(OP_LOAD_SIZE, '0, '0, 7'd127);
    for (int i = 0; i < 6; i++) send(OP_LOAD_MODEL, ID_W'(20 + i), 10'd1023, '0);
    send(OP_ALLOC, '0, '0, '0);
    drain_and_config(GPU_W'(1));
    hold_off = 1;
    for (int i = 0; i < 24; i++) random_run();
    drain_and_config(GPU_W'(15));
    for (int i = 0; i < 6; i++) random_run();
    drain_and_config(GPU_W'(0));
    for (int i = 0; i < 3; i++) random_run();
    drain_and_config(GPU_W'($urandom_range(2, 7)));
    for (int i = 0; i < 14; i++) random_run();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
